>>> hdl/keyed_segment_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// keyed segment allocator assertion macros
// shared property forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef KEYED_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH
`define KEYED_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define KSA_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define KSA_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> hdl/ksa_pkg.sv
// ----------------------------------------------------------------------------
// ksa_pkg
// payload types, control groups and constants of the segment allocator
// ----------------------------------------------------------------------------
package ksa_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_BYTES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENTS_IN_USE = 2'd1;

    localparam logic [31:0] SEGMENT_BYTES_RESET   = 32'd1048576;
    localparam logic [6:0]  SEGMENTS_IN_USE_RESET = 7'd64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [31:0] topic;
        logic [31:0] partition;
        logic [31:0] segment_number;
    } ksa_key_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] topic;
        logic [31:0] partition;
        logic [31:0] segment_number;
    } ksa_in_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  segment_index;
        logic [37:0] segment_offset;
        logic        free_available;
    } ksa_out_t;

    typedef struct packed {
        logic pop;
        logic push;
        logic init;
    } ksa_fl_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } ksa_fl_stat_t;

    typedef struct packed {
        logic alloc;
        logic release_key;
        logic init;
    } ksa_kt_ctl_t;

endpackage

>>> hdl/ksa_ram.sv
// ----------------------------------------------------------------------------
// ksa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ksa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/ksa_free_list.sv
// ----------------------------------------------------------------------------
// ksa_free_list
// fifo of idle segment indexes with head prefetch and write tracking
// ----------------------------------------------------------------------------
module ksa_free_list #(
    parameter int NUM_SEGMENTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ksa_pkg::ksa_fl_ctl_t              ctl,
    input  logic [$clog2(NUM_SEGMENTS)-1:0]   push_data,
    input  logic [$clog2(NUM_SEGMENTS+1)-1:0] init_count,
    output logic [$clog2(NUM_SEGMENTS)-1:0]   head_data,
    output ksa_pkg::ksa_fl_stat_t             stat
);

    localparam int IW = $clog2(NUM_SEGMENTS);
    localparam int CW = $clog2(NUM_SEGMENTS + 1);
    localparam int RST_CNT = (NUM_SEGMENTS < int'(ksa_pkg::SEGMENTS_IN_USE_RESET)) ?
                             NUM_SEGMENTS : int'(ksa_pkg::SEGMENTS_IN_USE_RESET);
    localparam int RST_BASE = (RST_CNT == NUM_SEGMENTS) ? 0 : RST_CNT;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] base_reg, base_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] wcount_reg, wcount_next;
    logic          init_sel_reg, init_sel_next;
    logic [IW-1:0] init_val_reg;
    logic          byp_sel_reg, byp_sel_next;
    logic [IW-1:0] byp_val_reg;
    logic [IW-1:0] ram_q;
    logic [IW:0]   head_ofs;
    logic          written;
    logic          do_push;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
        wrap_inc = (x == IW'(NUM_SEGMENTS - 1)) ? '0 : x + 1'b1;
    endfunction

    assign do_push = ctl.push && !ctl.init;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        wcount_next = wcount_reg;
        if (ctl.init)
        begin
            head_next   = '0;
            base_next   = (init_count == CW'(NUM_SEGMENTS)) ? '0 : IW'(init_count);
            tail_next   = base_next;
            count_next  = init_count;
            wcount_next = '0;
        end
        else if (ctl.pop)
        begin
            head_next  = wrap_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
        else if (ctl.push)
        begin
            tail_next  = wrap_inc(tail_reg);
            count_next = count_reg + 1'b1;
            if (wcount_reg != CW'(NUM_SEGMENTS))
            begin
                wcount_next = wcount_reg + 1'b1;
            end
        end
    end

    // position of the next head relative to the first tail slot since init
    always_comb
    begin
        if (head_next >= base_reg)
        begin
            head_ofs = {1'b0, head_next} - {1'b0, base_reg};
        end
        else
        begin
            head_ofs = {1'b0, head_next} + (IW+1)'(NUM_SEGMENTS) - {1'b0, base_reg};
        end
        written       = head_ofs < (IW+1)'(wcount_reg);
        init_sel_next = ctl.init || !written;
        byp_sel_next  = do_push && (tail_reg == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= IW'(RST_BASE);
            base_reg     <= IW'(RST_BASE);
            count_reg    <= CW'(RST_CNT);
            wcount_reg   <= '0;
            init_sel_reg <= 1'b1;
            init_val_reg <= '0;
            byp_sel_reg  <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            base_reg     <= base_next;
            count_reg    <= count_next;
            wcount_reg   <= wcount_next;
            init_sel_reg <= init_sel_next;
            init_val_reg <= head_next;
            byp_sel_reg  <= byp_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_val_reg <= push_data;
    end

    ksa_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_SEGMENTS)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (tail_reg),
        .wdata (push_data),
        .raddr (head_next),
        .rdata (ram_q)
    );

    assign head_data  = byp_sel_reg ? byp_val_reg : (init_sel_reg ? init_val_reg : ram_q);
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(NUM_SEGMENTS));
    assign stat.last  = (count_reg == CW'(1));

endmodule

>>> hdl/ksa_key_table.sv
// ----------------------------------------------------------------------------
// ksa_key_table
// content addressed map from segment key to segment index
// ----------------------------------------------------------------------------
module ksa_key_table #(
    parameter int NUM_SEGMENTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ksa_pkg::ksa_kt_ctl_t            ctl,
    input  ksa_pkg::ksa_key_t               key,
    input  logic [$clog2(NUM_SEGMENTS)-1:0] seg_in,
    output logic                            hit,
    output logic [$clog2(NUM_SEGMENTS)-1:0] seg_out
);

    localparam int IW = $clog2(NUM_SEGMENTS);

    logic [NUM_SEGMENTS-1:0] valid_reg;
    ksa_pkg::ksa_key_t       key_reg [NUM_SEGMENTS];
    logic [IW-1:0]           seg_reg [NUM_SEGMENTS];
    logic [NUM_SEGMENTS-1:0] match;
    logic [NUM_SEGMENTS-1:0] vacant;
    logic [NUM_SEGMENTS-1:0] first_vacant;
    logic [NUM_SEGMENTS-1:0] target;

    always_comb
    begin
        seg_out = '0;
        for (int i = 0; i < NUM_SEGMENTS; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == key);
            seg_out  = seg_out | (match[i] ? seg_reg[i] : '0);
        end
        hit          = |match;
        vacant       = ~valid_reg;
        first_vacant = vacant & (~vacant + 1'b1);
        target       = hit ? match : first_vacant;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.init)
        begin
            valid_reg <= '0;
        end
        else if (ctl.alloc)
        begin
            valid_reg <= valid_reg | target;
        end
        else if (ctl.release_key)
        begin
            valid_reg <= valid_reg & ~match;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SEGMENTS; i++)
        begin
            if (ctl.alloc && !ctl.init && target[i])
            begin
                key_reg[i] <= key;
                seg_reg[i] <= seg_in;
            end
        end
    end

endmodule

>>> hdl/keyed_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// keyed_segment_allocator_top
// segment pool allocator with fifo free list and keyed segment map
// ----------------------------------------------------------------------------
// requests enter on in_valid/in_ready as one ksa_in_t transfer: operation
// selects allocate or free, topic/partition/segment_number form the key
// every request yields one ksa_out_t transfer on out_valid/out_ready with
// ok, segment index, byte offset (index times segment_bytes) and whether a
// free segment remains
// a transfer is held in an input register and resolved when it fires:
// key match, fifo pop or push and offset multiply all happen as it fires,
// and the result is registered into out_valid and out_data
// throughput is one request per cycle while out_ready holds, set by the
// combinational key match and the prefetched head entry of the free list ram
// a stalled receiver holds the result register; the input register fills
// and in_ready drops until the result is taken
// reset and any write of segments_in_use place indexes 0 upward in the free
// list and drop every key mapping; no clearing pass is needed
// config writes (cfg_write, cfg_index, cfg_data), unchecked by the block,
// take effect at once and must be issued only while no request is outstanding
// ----------------------------------------------------------------------------
`include "keyed_segment_allocator_top_assert.svh"

module keyed_segment_allocator_top #(
    parameter int NUM_SEGMENTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ksa_pkg::ksa_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ksa_pkg::ksa_out_t                   out_data,
    input  logic                                cfg_write,
    input  logic [ksa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ksa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IW = $clog2(NUM_SEGMENTS);
    localparam int CW = $clog2(NUM_SEGMENTS + 1);

    logic                  s1_valid_reg;
    ksa_pkg::ksa_in_t      s1_data_reg;
    logic                  out_valid_reg;
    ksa_pkg::ksa_out_t     out_data_reg, out_data_next;
    logic [31:0]           seg_bytes_reg;
    logic                  fire;
    logic                  is_alloc;
    logic                  init;
    logic [CW-1:0]         init_count;
    ksa_pkg::ksa_fl_ctl_t  fl_ctl;
    ksa_pkg::ksa_fl_stat_t fl_stat;
    ksa_pkg::ksa_kt_ctl_t  kt_ctl;
    ksa_pkg::ksa_key_t     key;
    logic [IW-1:0]         head_data;
    logic                  hit;
    logic [IW-1:0]         hit_seg;
    logic [IW-1:0]         idx;
    logic                  ok;
    logic [IW+31:0]        product;
    logic                  result_zero;

    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;
    assign is_alloc = (s1_data_reg.operation == ksa_pkg::OP_ALLOC);
    assign init     = cfg_write && (cfg_index == ksa_pkg::REG_SEGMENTS_IN_USE);

    always_comb
    begin
        if (32'(cfg_data[6:0]) > 32'(NUM_SEGMENTS))
        begin
            init_count = CW'(NUM_SEGMENTS);
        end
        else
        begin
            init_count = CW'(cfg_data[6:0]);
        end
    end

    assign key.topic          = s1_data_reg.topic;
    assign key.partition      = s1_data_reg.partition;
    assign key.segment_number = s1_data_reg.segment_number;

    assign fl_ctl.pop  = fire && is_alloc && !fl_stat.empty;
    assign fl_ctl.push = fire && !is_alloc && hit && !fl_stat.full;
    assign fl_ctl.init = init;

    assign kt_ctl.alloc       = fl_ctl.pop;
    assign kt_ctl.release_key = fire && !is_alloc && hit;
    assign kt_ctl.init        = init;

    ksa_free_list #(
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_free_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (fl_ctl),
        .push_data  (hit_seg),
        .init_count (init_count),
        .head_data  (head_data),
        .stat       (fl_stat)
    );

    ksa_key_table #(
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_key_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (kt_ctl),
        .key     (key),
        .seg_in  (head_data),
        .hit     (hit),
        .seg_out (hit_seg)
    );

    always_comb
    begin
        ok  = is_alloc ? !fl_stat.empty : hit;
        idx = '0;
        if (ok)
        begin
            idx = is_alloc ? head_data : hit_seg;
        end
        product = (IW+32)'(idx) * (IW+32)'(seg_bytes_reg);
        out_data_next.ok             = ok;
        out_data_next.segment_index  = 6'(idx);
        out_data_next.segment_offset = 38'(product);
        if (fl_ctl.pop)
        begin
            out_data_next.free_available = !fl_stat.last;
        end
        else if (fl_ctl.push)
        begin
            out_data_next.free_available = 1'b1;
        end
        else
        begin
            out_data_next.free_available = !fl_stat.empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seg_bytes_reg <= ksa_pkg::SEGMENT_BYTES_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write && (cfg_index == ksa_pkg::REG_SEGMENT_BYTES))
            begin
                seg_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign result_zero = (out_data_reg.segment_index == 6'd0) &&
                         (out_data_reg.segment_offset == 38'd0);

    // checks
    `KSA_CHECK_NEXT(a_fire_gives_result, fire, out_valid_reg)
    `KSA_CHECK_NOW(a_fail_is_zero, out_valid_reg && !out_data_reg.ok, result_zero)
    `KSA_CHECK_NEXT(a_stage_holds, s1_valid_reg && !fire, s1_valid_reg && $stable(s1_data_reg))
    `KSA_CHECK_NEXT(a_last_pop_empties, fl_ctl.pop && fl_stat.last, !out_data_reg.free_available)

endmodule
